// ----- hdl/rrps_pkg.sv -----
// Shared types, codes and helpers for the round-robin process scheduler.
package rrps_pkg;

  localparam logic [15:0] SLICE_RESET = 16'd200;
  localparam logic [15:0] STACK_INIT  = 16'hFF00;
  localparam logic [15:0] FIRST_SEG   = 16'h2000;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_CREATE    = 2'd1,
    CMD_KILL      = 2'd2,
    CMD_TERMINATE = 2'd3
  } rrps_command_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_COUNT,
    OP_FIRST,
    OP_SWITCH,
    OP_KEEP,
    OP_CREATE,
    OP_FULL,
    OP_KILL,
    OP_TERMINATE
  } rrps_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } rrps_state_t;

  typedef struct packed {
    logic     load;
    rrps_op_t op;
  } rrps_cmd_t;

  typedef struct packed {
    rrps_command_t command;
    logic          expired;
    logic          first_done;
    logic          next_found;
    logic          free_found;
  } rrps_status_t;

  // Segment of a slot: (slot + 2) * 0x1000, kept to 16 bits.
  function automatic logic [15:0] seg_of(input logic [4:0] slot);
    logic [3:0] page;
    page = slot[3:0] + 4'd2;
    return {page, 12'h000};
  endfunction

endpackage

// ----- hdl/rrps_ctrl.sv -----
// Controller: beat handshakes and per-command operation selection.
module rrps_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  rrps_pkg::rrps_status_t status,
  output rrps_pkg::rrps_cmd_t   cmd
);
  import rrps_pkg::*;

  rrps_state_t state;
  rrps_state_t state_next;
  logic        out_valid;
  logic        out_valid_next;
  logic        out_free;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
          unique case (status.command)
            CMD_TICK: begin
              if (!status.expired) begin
                cmd.op = OP_COUNT;
              end else if (!status.first_done) begin
                cmd.op = OP_FIRST;
              end else if (status.next_found) begin
                cmd.op = OP_SWITCH;
              end else begin
                cmd.op = OP_KEEP;
              end
            end
            CMD_CREATE: begin
              cmd.op = status.free_found ? OP_CREATE : OP_FULL;
            end
            CMD_KILL:      cmd.op = OP_KILL;
            CMD_TERMINATE: cmd.op = OP_TERMINATE;
            default:       cmd.op = OP_NONE;
          endcase
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.op != OP_NONE) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_op_only_in_exec: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_NONE) |-> (state == ST_EXEC))
    else $error("operation issued outside execute state");

  a_op_needs_space: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_NONE) |-> (!out_valid || m_tready))
    else $error("result written over a beat not yet taken");

  a_op_gives_beat: assert property (@(posedge clk) disable iff (rst)
    (cmd.op != OP_NONE) |=> out_valid)
    else $error("result register loaded without raising valid");

  a_accept_goes_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_EXEC))
    else $error("accepted beat not taken to execute state");

endmodule

// ----- hdl/rrps_datapath.sv -----
// Datapath: slot table, tick counter, round-robin pick and result register.
module rrps_datapath #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  rrps_pkg::rrps_cmd_t    cmd,
  output rrps_pkg::rrps_status_t status,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_data,
  input  logic [1:0]             in_command,
  input  logic [15:0]            in_run_segment,
  input  logic [15:0]            in_run_stack,
  input  logic [2:0]             in_target_slot,
  output logic [15:0]            resume_segment,
  output logic [15:0]            resume_stack,
  output logic                   switched,
  output logic [2:0]             chosen_slot,
  output logic                   table_full
);
  import rrps_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);

  logic [1:0]            command;
  logic [15:0]           run_segment;
  logic [15:0]           run_stack;
  logic [2:0]            target_slot;
  logic [15:0]           time_slice;
  logic [SLOT_COUNT-1:0] active;
  logic [15:0]           saved_stack [SLOT_COUNT];
  logic [SLOT_W-1:0]     running_slot;
  logic [15:0]           tick_count;
  logic                  first_done;

  logic [SLOT_COUNT-1:0] above;
  logic [SLOT_COUNT-1:0] below;
  logic [SLOT_COUNT-1:0] cand;
  logic [SLOT_COUNT-1:0] cand_first;
  logic [SLOT_COUNT-1:0] free_vec;
  logic [SLOT_COUNT-1:0] free_first;
  logic [SLOT_W-1:0]     next_slot;
  logic [SLOT_W-1:0]     free_slot;
  logic [SLOT_W-1:0]     kill_slot;
  logic                  kill_ok;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      above[i] = active[i] && (SLOT_W'(i) > running_slot);
      below[i] = active[i] && (SLOT_W'(i) < running_slot);
    end
    cand       = (|above) ? above : below;
    cand_first = cand & (~cand + SLOT_COUNT'(1));
    free_vec   = ~active;
    free_first = free_vec & (~free_vec + SLOT_COUNT'(1));
    next_slot  = '0;
    free_slot  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      next_slot = next_slot | (cand_first[i] ? SLOT_W'(i) : '0);
      free_slot = free_slot | (free_first[i] ? SLOT_W'(i) : '0);
    end
  end

  assign kill_slot = SLOT_W'(target_slot);
  assign kill_ok   = (5'(target_slot) < 5'(SLOT_COUNT));

  assign status.command    = rrps_command_t'(command);
  assign status.expired    = (tick_count == time_slice);
  assign status.first_done = first_done;
  assign status.next_found = |cand;
  assign status.free_found = |free_vec;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      command     <= in_command;
      run_segment <= in_run_segment;
      run_stack   <= in_run_stack;
      target_slot <= in_target_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_slice <= SLICE_RESET;
    end else if (cfg_we) begin
      time_slice <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= '0;
      running_slot <= '0;
      tick_count   <= '0;
      first_done   <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        saved_stack[i] <= STACK_INIT;
      end
    end else begin
      unique case (cmd.op)
        OP_NONE: begin
        end
        OP_COUNT: tick_count <= tick_count + 16'd1;
        OP_FIRST: begin
          saved_stack[running_slot] <= run_stack;
          tick_count                <= 16'd1;
          first_done                <= 1'b1;
          running_slot              <= '0;
        end
        OP_SWITCH: begin
          saved_stack[running_slot] <= run_stack;
          tick_count                <= '0;
          running_slot              <= next_slot;
        end
        OP_KEEP: begin
          saved_stack[running_slot] <= run_stack;
          tick_count                <= '0;
        end
        OP_CREATE: begin
          active[free_slot]      <= 1'b1;
          saved_stack[free_slot] <= STACK_INIT;
          tick_count             <= time_slice;
        end
        OP_FULL: begin
        end
        OP_KILL: begin
          if (kill_ok) begin
            active[kill_slot]      <= 1'b0;
            saved_stack[kill_slot] <= STACK_INIT;
          end
        end
        OP_TERMINATE: begin
          active[running_slot]      <= 1'b0;
          saved_stack[running_slot] <= STACK_INIT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) begin
      resume_segment <= '0;
      resume_stack   <= '0;
      switched       <= 1'b0;
      chosen_slot    <= '0;
      table_full     <= 1'b0;
      unique case (cmd.op)
        OP_COUNT, OP_KEEP: begin
          resume_segment <= run_segment;
          resume_stack   <= run_stack;
          chosen_slot    <= 3'(running_slot);
        end
        OP_FIRST: begin
          resume_segment <= FIRST_SEG;
          resume_stack   <= STACK_INIT;
          switched       <= 1'b1;
        end
        OP_SWITCH: begin
          resume_segment <= seg_of(5'(next_slot));
          resume_stack   <= saved_stack[next_slot];
          switched       <= 1'b1;
          chosen_slot    <= 3'(next_slot);
        end
        OP_CREATE: begin
          resume_segment <= seg_of(5'(free_slot));
          resume_stack   <= STACK_INIT;
          chosen_slot    <= 3'(free_slot);
        end
        OP_FULL: table_full <= 1'b1;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/round_robin_process_scheduler_top.sv -----
// Top level of the round-robin time-slice process scheduler.
//
// Input beats on s_* carry a command in s_tuser (tick, create, kill,
// terminate) and the interrupted program's segment, stack pointer and a kill
// target in s_tdata. Every input beat yields exactly one result beat on m_*:
// the segment and stack to resume and the chosen slot in m_tdata, with the
// switched and table-full flags in m_tuser.
// The time slice must be written on the cfg_* channel only while the block is
// idle; the block itself does not enforce this. The channel is always ready.
// An input beat is registered in the idle state and executed in the execute
// state; no new input beat is taken until it has executed. The round-robin pick
// over the slot table is done combinationally in the execute state.
// While a result waits on m_tready, the next input beat is still taken; its
// execution holds until the result register is free.
// Reset clears every slot, sets all saved stacks to 0xFF00, zeroes the
// running slot and tick count, and sets the time slice to 200.
module round_robin_process_scheduler_top #(
  parameter int SLOT_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // run_segment, run_stack, target_slot, zero pad
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // resume_segment, resume_stack, chosen_slot, zero pad
  output logic [1:0]  m_tuser,   // switched, table_full
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import rrps_pkg::*;

  rrps_cmd_t    cmd;
  rrps_status_t status;
  logic [15:0]  resume_segment;
  logic [15:0]  resume_stack;
  logic         switched;
  logic [2:0]   chosen_slot;
  logic         table_full;

  assign cfg_ready = 1'b1;

  rrps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rrps_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .in_command     (s_tuser),
    .in_run_segment (s_tdata[15:0]),
    .in_run_stack   (s_tdata[31:16]),
    .in_target_slot (s_tdata[34:32]),
    .resume_segment (resume_segment),
    .resume_stack   (resume_stack),
    .switched       (switched),
    .chosen_slot    (chosen_slot),
    .table_full     (table_full)
  );

  assign m_tdata = {5'd0, chosen_slot, resume_stack, resume_segment};
  assign m_tuser = {table_full, switched};

endmodule
